/* rtl/sstq_pkg.sv */
// Package for the sorted sleep timer queue: widths, result codes and
// shared types. Depends on nothing.
`default_nettype none
package sstq_pkg;
   localparam int QueueDepthDefault = 64;
   localparam int TimeWidth = 32;
   localparam int IdWidth = 16;
   localparam int TpsWidth = 20;
   localparam logic [TpsWidth-1:0] TpsReset = 20'd1000000;

   localparam logic [1:0] KIND_ACCEPTED = 2'd0;
   localparam logic [1:0] KIND_NEGATIVE = 2'd1;
   localparam logic [1:0] KIND_FULL     = 2'd2;
   localparam logic [1:0] KIND_WAKE     = 2'd3;

   localparam logic OP_SLEEP = 1'b0;
   localparam logic OP_TICK  = 1'b1;

   // Classified command passed from the front end to the back end.
   typedef struct packed {
      logic                 is_tick;
      logic                 negative;
      logic [IdWidth-1:0]   id;
      logic [TimeWidth-1:0] time_val;
   } cmd_type;
endpackage
`default_nettype wire

/* rtl/sstq_front.sv */
// Front end: accepts requests, computes saturated wake times and places
// classified commands in a two-entry queue. Depends on sstq_pkg.
`default_nettype none
module sstq_front import sstq_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   output logic                      in_ready,
   input  wire logic                 in_op,
   input  wire logic [IdWidth-1:0]   in_id,
   input  wire logic signed [15:0]   in_sec,
   input  wire logic [TimeWidth-1:0] in_time,
   input  wire logic [TpsWidth-1:0]  tps,
   output logic                      cmd_valid,
   input  wire logic                 cmd_ready,
   output cmd_type                   cmd
);
   // Stage 1 registers the product; stage 2 adds and saturates into the queue.
   logic                 s1_valid_ff, s1_valid_in;
   logic                 s1_tick_ff, s1_neg_ff;
   logic [IdWidth-1:0]   s1_id_ff;
   logic [TimeWidth-1:0] s1_time_ff;
   logic [34:0]          s1_prod_ff;
   cmd_type              q_ff [2];
   logic [1:0]           q_cnt_ff, q_cnt_in;
   logic                 q_rd_ff, q_wr_ff;
   logic                 push, pop;
   logic [35:0]          sum;
   cmd_type              new_cmd;

   // One stage plus up to two queued entries; stall stage 1 when queue is full.
   assign in_ready  = !s1_valid_ff;
   assign push      = s1_valid_ff && (q_cnt_ff != 2'd2);
   assign cmd_valid = q_cnt_ff != 2'd0;
   assign pop       = cmd_valid && cmd_ready;
   assign cmd       = q_ff[q_rd_ff];
   assign sum       = {4'd0, s1_time_ff} + {1'b0, s1_prod_ff};

   always_comb begin
      new_cmd.is_tick  = s1_tick_ff;
      new_cmd.negative = s1_neg_ff;
      new_cmd.id       = s1_id_ff;
      if (s1_tick_ff) begin
         new_cmd.time_val = s1_time_ff;
      end else if (sum[35:32] != 4'd0) begin
         new_cmd.time_val = '1;
      end else begin
         new_cmd.time_val = sum[31:0];
      end
   end

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (push) begin
         s1_valid_in = 1'b0;
      end
      if (in_valid && in_ready) begin
         s1_valid_in = 1'b1;
      end
      q_cnt_in = q_cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         q_cnt_ff    <= 2'd0;
         q_rd_ff     <= 1'b0;
         q_wr_ff     <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         q_cnt_ff    <= q_cnt_in;
         if (pop) begin
            q_rd_ff <= !q_rd_ff;
         end
         if (push) begin
            q_wr_ff <= !q_wr_ff;
         end
      end
      if (in_valid && in_ready) begin
         s1_tick_ff <= in_op == OP_TICK;
         s1_neg_ff  <= in_sec[15];
         s1_id_ff   <= in_id;
         s1_time_ff <= in_time;
         s1_prod_ff <= {20'd0, in_sec[14:0]} * {15'd0, tps};
      end
      if (push) begin
         q_ff[q_wr_ff] <= new_cmd;
      end
   end
endmodule
`default_nettype wire

/* rtl/sstq_back.sv */
// Back end: holds the sorted queue in flip-flop rows, inserts with a
// parallel compare-and-shift, and drains due entries one per cycle while
// the result side is ready. Depends on sstq_pkg.
`default_nettype none
module sstq_back import sstq_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               cmd_valid,
   output logic                    cmd_ready,
   input  wire cmd_type            cmd,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output logic [1:0]              out_kind,
   output logic [IdWidth-1:0]      out_id,
   output logic                    out_last
);
   localparam int CntWidth = $clog2(QUEUE_DEPTH + 1);
   localparam int Dep = QUEUE_DEPTH;

   // Each row compares only with its own and its neighbour's value, like a
   // systolic sorted list; nothing is read at a signal-chosen address.
   logic [TimeWidth-1:0] time_ff [QUEUE_DEPTH];
   logic [IdWidth-1:0]   id_ff   [QUEUE_DEPTH];
   logic [CntWidth-1:0]  cnt_ff, cnt_in;
   logic                 drain_ff, drain_in;
   logic [TimeWidth-1:0] now_ff;
   logic                 out_valid_ff, out_valid_in;
   logic [1:0]           kind_ff, kind_in;
   logic [IdWidth-1:0]   oid_ff, oid_in;
   logic                 last_ff, last_in;
   logic                 take, do_insert, do_pop, head_due, next_due;
   logic                 slot_free;
   logic [QUEUE_DEPTH-1:0] later;

   assign out_valid = out_valid_ff;
   assign out_kind  = kind_ff;
   assign out_id    = oid_ff;
   assign out_last  = last_ff;

   assign slot_free = !out_valid_ff || out_ready;
   assign cmd_ready = !drain_ff && slot_free;
   assign take      = cmd_valid && cmd_ready;
   assign head_due  = (cnt_ff != '0) && (time_ff[0] <= now_ff);
   assign next_due  = (cnt_ff > CntWidth'(1)) && (time_ff[1] <= now_ff);
   assign do_pop    = drain_ff && slot_free && head_due;
   assign do_insert = take && !cmd.is_tick && !cmd.negative
                      && (cnt_ff != CntWidth'(Dep));

   always_comb begin
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         later[i] = (CntWidth'(i) >= cnt_ff) || (time_ff[i] > cmd.time_val);
      end
   end

   always_comb begin
      cnt_in       = cnt_ff;
      drain_in     = drain_ff;
      out_valid_in = out_valid_ff && !out_ready;
      kind_in      = kind_ff;
      oid_in       = oid_ff;
      last_in      = last_ff;
      if (take && cmd.is_tick) begin
         drain_in = 1'b1;
      end else if (take) begin
         out_valid_in = 1'b1;
         oid_in       = cmd.id;
         last_in      = 1'b1;
         if (cmd.negative) begin
            kind_in = KIND_NEGATIVE;
         end else if (cnt_ff == CntWidth'(Dep)) begin
            kind_in = KIND_FULL;
         end else begin
            kind_in = KIND_ACCEPTED;
            cnt_in  = cnt_ff + CntWidth'(1);
         end
      end
      if (drain_ff && !head_due) begin
         drain_in = 1'b0;
      end else if (do_pop) begin
         out_valid_in = 1'b1;
         kind_in      = KIND_WAKE;
         oid_in       = id_ff[0];
         last_in      = !next_due;
         cnt_in       = cnt_ff - CntWidth'(1);
         drain_in     = next_due;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         drain_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         drain_ff     <= drain_in;
         out_valid_ff <= out_valid_in;
      end
      kind_ff <= kind_in;
      oid_ff  <= oid_in;
      last_ff <= last_in;
      if (take && cmd.is_tick) begin
         now_ff <= cmd.time_val;
      end
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         if (do_insert && later[i]) begin
            if (i == 0 || !later[(i == 0) ? 0 : i-1]) begin
               time_ff[i] <= cmd.time_val;
               id_ff[i]   <= cmd.id;
            end else begin
               time_ff[i] <= time_ff[(i == 0) ? 0 : i-1];
               id_ff[i]   <= id_ff[(i == 0) ? 0 : i-1];
            end
         end else if (do_pop) begin
            if (i < QUEUE_DEPTH - 1) begin
               time_ff[i] <= time_ff[(i < QUEUE_DEPTH - 1) ? i+1 : i];
               id_ff[i]   <= id_ff[(i < QUEUE_DEPTH - 1) ? i+1 : i];
            end
         end
      end
   end
endmodule
`default_nettype wire

/* rtl/sorted_sleep_timer_queue_top.sv */
// A sleep request's one result passes the product register, then the wake-time add
// into the queue, then the insert that loads the result register; the first wake of
// a tick follows once the back end has taken the tick and set its drain flag.
// The front end takes no new request while stage 1 still holds one; a tick holds the
// back end while it drains due entries, one per cycle when the result side is ready.
// Reset (synchronous, active high) empties the queue and sets
// ticks_per_second to one million; stored rows need no clearing.
`default_nettype none
module sorted_sleep_timer_queue_top import sstq_pkg::*; #(
   parameter int QUEUE_DEPTH = QueueDepthDefault
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_ready,
   input  wire logic                 req_operation,
   input  wire logic [IdWidth-1:0]   req_process_id,
   input  wire logic signed [15:0]   req_seconds,
   input  wire logic [TimeWidth-1:0] req_current_time,
   output logic                      rsp_valid,
   input  wire logic                 rsp_ready,
   output logic [1:0]                rsp_kind,
   output logic [IdWidth-1:0]        rsp_woken_id,
   output logic                      rsp_last,
   input  wire logic                 psel,
   input  wire logic                 penable,
   input  wire logic                 pwrite,
   input  wire logic                 paddr,
   input  wire logic [31:0]          pwdata,
   output logic [31:0]               prdata,
   output logic                      pready
);
   // The configuration port holds one register, ticks_per_second, at
   // byte address 0; the single address bit is the word index.
   logic [TpsWidth-1:0] tps_ff;
   logic                cmd_valid, cmd_ready;
   cmd_type             cmd;

   assign pready = 1'b1;
   assign prdata = (paddr == 1'b0) ? {12'd0, tps_ff} : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         tps_ff <= TpsReset;
      end else if (psel && penable && pwrite && paddr == 1'b0) begin
         tps_ff <= pwdata[TpsWidth-1:0];
      end
   end

   // The front end computes the wake time while the back end may still be
   // draining woken sleepers; the queue between them decouples the two.
   sstq_front u_front (
      .clock, .reset,
      .in_valid(req_valid), .in_ready(req_ready), .in_op(req_operation),
      .in_id(req_process_id), .in_sec(req_seconds), .in_time(req_current_time),
      .tps(tps_ff), .cmd_valid, .cmd_ready, .cmd
   );

   sstq_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd,
      .out_valid(rsp_valid), .out_ready(rsp_ready), .out_kind(rsp_kind),
      .out_id(rsp_woken_id), .out_last(rsp_last)
   );
endmodule
`default_nettype wire

/* rtl/sstq_checker.sv */
// Port-level checker for the sorted sleep timer queue, bound to the top
// level. Depends on sstq_pkg.
`default_nettype none
module sstq_checker import sstq_pkg::*; (
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_kind,
   input wire logic       rsp_last,
   input wire logic       pready
);
   // Only wake results may be non-final.
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_WAKE) else $error("non-final non-wake");
   // A stalled result stays valid and holds its kind.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind)) else $error("result dropped");
   // No result at the first edge after reset is released.
   a_reset: assert property (@(posedge clock) !reset && $past(reset) |-> !rsp_valid)
      else $error("result after reset");
   a_pready: assert property (@(posedge clock) pready) else $error("pready low");
endmodule
bind sorted_sleep_timer_queue_top sstq_checker u_checker (
   .clock, .reset, .rsp_valid, .rsp_ready, .rsp_kind, .rsp_last, .pready
);
`default_nettype wire

/* tb/sv/sorted_sleep_timer_queue_top_tb.sv */
// Self-checking testbench for the sorted sleep timer queue top level.
// Depends on sstq_pkg and sorted_sleep_timer_queue_top; needs no other file.
`default_nettype none
module sorted_sleep_timer_queue_top_tb;
   import sstq_pkg::*;

   localparam int Depth = QueueDepthDefault;
   // The only register, ticks_per_second, sits at byte address zero.
   localparam logic TpsAddr = 1'b0;
   localparam int CycleLimit = 2000000;
   // Settling time after the last expected result; a tick that wakes nobody
   // gives no result, so this covers a full drain of the back end as well.
   localparam int SettleCycles = Depth + 20;

   typedef struct {
      logic [1:0]         kind;
      logic [IdWidth-1:0] id;
      logic               last;
   } wake_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic                 req_operation = OP_SLEEP;
   logic [IdWidth-1:0]   req_process_id = '0;
   logic signed [15:0]   req_seconds = '0;
   logic [TimeWidth-1:0] req_current_time = '0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [1:0]           rsp_kind;
   logic [IdWidth-1:0]   rsp_woken_id;
   logic                 rsp_last;
   logic                 psel = 1'b0;
   logic                 penable = 1'b0;
   logic                 pwrite = 1'b0;
   logic                 paddr = TpsAddr;
   logic [31:0]          pwdata = '0;
   logic [31:0]          prdata;
   logic                 pready;

   // Model state: the sorted sleepers and the scale register.
   logic [TimeWidth-1:0] model_wake[$];
   logic [IdWidth-1:0]   model_ids[$];
   logic [TpsWidth-1:0]  model_tps;
   wake_result_type      pending_results[$];

   int  fail_count = 0;
   int  cycle_count = 0;
   int  rsp_stall = 0;
   bit  rsp_hold_off = 1'b0; // set to make the result side stall freely
   bit  no_gaps = 1'b0;      // set for stretches with back-to-back requests
   logic [TimeWidth-1:0] sim_now = '0;

   sorted_sleep_timer_queue_top #(.QUEUE_DEPTH(Depth)) dut (.*);

   always #4 clock = ~clock;

   // Run limit: a hung handshake must not leave the simulation spinning.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // Random gap length: mostly short, now and then a long one.
   function automatic int gap_length();
      if ($urandom_range(9) == 0) return $urandom_range(40, 10);
      return $urandom_range(2);
   endfunction

   // The result side stalls for random stretches, mostly short and a few long.
   always @(negedge clock) begin
      if (reset || !rsp_hold_off) begin
         rsp_ready = 1'b1;
         rsp_stall = 0;
      end else if (rsp_stall > 0) begin
         rsp_ready = 1'b0;
         rsp_stall--;
      end else if ($urandom_range(3) == 0) begin
         rsp_stall = gap_length();
         rsp_ready = (rsp_stall == 0);
         if (rsp_stall > 0) rsp_stall--;
      end else begin
         rsp_ready = 1'b1;
      end
   end

   // Work out the results one request causes and update the sleeper list.
   task automatic predict_request(input logic op, input logic [IdWidth-1:0] pid,
                                  input logic signed [15:0] sec,
                                  input logic [TimeWidth-1:0] now);
      logic [63:0]          sum;
      logic [TimeWidth-1:0] wake;
      int                   slot;
      int                   due;
      wake_result_type      r;
      if (op == OP_SLEEP) begin
         r.id = pid;
         r.last = 1'b1;
         if (sec < 0) begin
            r.kind = KIND_NEGATIVE;
         end else if (model_wake.size() >= Depth) begin
            r.kind = KIND_FULL;
         end else begin
            sum = 64'(now) + 64'(unsigned'(sec)) * 64'(model_tps);
            wake = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
            // Ties go behind the entries already queued.
            slot = 0;
            while (slot < model_wake.size() && model_wake[slot] <= wake) slot++;
            model_wake.insert(slot, wake);
            model_ids.insert(slot, pid);
            r.kind = KIND_ACCEPTED;
         end
         pending_results.push_back(r);
      end else begin
         due = 0;
         while (due < model_wake.size() && model_wake[due] <= now) due++;
         for (int i = 0; i < due; i++) begin
            r.kind = KIND_WAKE;
            r.id = model_ids.pop_front();
            r.last = (i == due - 1);
            void'(model_wake.pop_front());
            pending_results.push_back(r);
         end
      end
   endtask

   // Send one request. Called at a falling edge; returns at a falling edge
   // with valid either lowered for a gap or left high for the next request.
   task automatic send_request(input logic op, input logic [IdWidth-1:0] pid,
                               input logic signed [15:0] sec,
                               input logic [TimeWidth-1:0] now);
      int gap;
      req_operation = op;
      req_process_id = pid;
      req_seconds = sec;
      req_current_time = now;
      req_valid = 1'b1;
      do @(posedge clock); while (!req_ready);
      predict_request(op, pid, sec, now);
      @(negedge clock);
      gap = no_gaps ? 0 : gap_length();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   task automatic sleep_request(input logic [IdWidth-1:0] pid,
                                input logic signed [15:0] sec,
                                input logic [TimeWidth-1:0] now);
      send_request(OP_SLEEP, pid, sec, now);
   endtask

   // A tick carries random junk in the fields it does not use.
   task automatic tick_request(input logic [TimeWidth-1:0] now);
      send_request(OP_TICK, IdWidth'($urandom), 16'($urandom), now);
   endtask

   // Wait until every expected result has come and the back end has settled.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (SettleCycles) @(negedge clock);
   endtask

   // Register write (setup, access) followed by a read back; only when idle.
   task automatic write_tps(input logic [31:0] value);
      psel = 1'b1;
      pwrite = 1'b1;
      paddr = TpsAddr;
      pwdata = value;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      model_tps = value[TpsWidth-1:0];
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      do @(posedge clock); while (!pready);
      if (prdata[TpsWidth-1:0] !== model_tps) begin
         $error("ticks_per_second: expected %0d, actual %0d", model_tps,
                prdata[TpsWidth-1:0]);
         fail_count++;
      end
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
   endtask

   // Each result is checked against the oldest expectation.
   always @(posedge clock) begin
      wake_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            $error("unexpected result: kind %0d id %0d last %0d", rsp_kind,
                   rsp_woken_id, rsp_last);
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_kind !== want.kind) begin
               $error("kind: expected %0d, actual %0d", want.kind, rsp_kind);
               fail_count++;
            end
            if (rsp_woken_id !== want.id) begin
               $error("woken_id: expected %0d, actual %0d", want.id, rsp_woken_id);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0d, actual %0d", want.last, rsp_last);
               fail_count++;
            end
         end
      end
   end

   // Field extremes, negative and zero durations, ties, repeated ids,
   // saturation at the top of the time range, and ticks that wake nobody.
   task automatic test_directed();
      write_tps(TpsReset);
      sleep_request(16'h0000, 16'sh8000, 32'h0);
      sleep_request(16'hFFFF, -16'sd1, 32'hFFFF_FFFF);
      tick_request(32'h0);
      sleep_request(16'h0001, 16'sd0, 32'd100);
      sleep_request(16'h0002, 16'sd0, 32'd100);
      sleep_request(16'h0001, 16'sd0, 32'd100);
      tick_request(32'd99);
      tick_request(32'd100);
      sleep_request(16'hFFFF, 16'sh7FFF, 32'hFFFF_0000);
      sleep_request(16'hA5A5, 16'sd1, 32'hFFF0_0000);
      tick_request(32'hFFFF_FFFE);
      tick_request(32'hFFFF_FFFF);
      wait_idle();
      write_tps(32'd1);
      sleep_request(16'h5A5A, 16'sh7FFF, 32'h0);
      sleep_request(16'h1234, 16'sd3, 32'd5);
      tick_request(32'd7);
      tick_request(32'd8);
      tick_request(32'h7FFF);
      wait_idle();
   endtask

   // A zero scale and the largest 20-bit scale.
   task automatic test_scale_extremes();
      write_tps(32'd0);
      sleep_request(16'h0BAD, 16'sd500, 32'd40);
      tick_request(32'd39);
      tick_request(32'd40);
      wait_idle();
      write_tps(32'hFFFFF);
      sleep_request(16'h0C0C, 16'sd4096, 32'd0);
      tick_request(32'hFFFF_FFFF);
      wait_idle();
   endtask

   // Fill the queue, overrun it, then wake every sleeper with one tick.
   task automatic test_queue_full();
      write_tps(32'd1);
      no_gaps = 1'b1;
      for (int i = 0; i < Depth; i++)
         sleep_request(IdWidth'($urandom), 16'($urandom_range(300)), 32'd0);
      sleep_request(16'hF00D, 16'sd1, 32'd0);
      no_gaps = 1'b0;
      tick_request(32'hFFFF_FFFF);
      wait_idle();
   endtask

   // Mostly sleeps near the running time and ticks that move it on, with
   // some negative durations and some far jumps in time.
   task automatic random_phase(input logic [31:0] tps, input int count);
      logic signed [15:0] sec;
      write_tps(tps);
      for (int n = 0; n < count; n++) begin
         if ((n % 12) == 0) no_gaps = ($urandom_range(2) == 0);
         if ($urandom_range(9) < 6) begin
            case ($urandom_range(9))
               0:       sec = 16'($urandom_range(65535, 32768));
               1:       sec = 16'($urandom_range(32767));
               default: sec = 16'($urandom_range(40));
            endcase
            sleep_request(IdWidth'($urandom), sec,
                          ($urandom_range(9) == 0) ? 32'($urandom) : sim_now);
         end else begin
            case ($urandom_range(9))
               0:       tick_request(32'($urandom));
               1:       tick_request(32'hFFFF_FFFF);
               default: begin
                  sim_now = sim_now + 32'($urandom_range(60 * (tps % 1000 + 1)));
                  tick_request(sim_now);
               end
            endcase
         end
      end
      no_gaps = 1'b0;
      wait_idle();
   endtask

   initial begin
      model_tps = TpsReset;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_scale_extremes();
      rsp_hold_off = 1'b1;
      test_queue_full();
      random_phase(32'd1, 10);
      random_phase(32'($urandom_range(20, 2)), 10);
      random_phase(32'd1000000, 8);
      random_phase(32'd0, 7);
      random_phase(32'hFFFFF, 7);
      wait_idle();
      if (fail_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end
endmodule
`default_nettype wire
